[sv/assert_macros.svh]
// Assertion macros shared by the CRC block's modules.
// Needs nothing else; every assertion is clocked on a rising edge and
// disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CCRC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("CRC block assertion failed");

// The condition must never be seen at a clock edge outside reset.
`define CCRC_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("CRC block forbidden condition seen");

`endif

[sv/ccrc_pkg.sv]
// Types, register codes, reset values and the code byte selector of the CRC block.
// Has no dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package ccrc_pkg;

   localparam int MAX_CRC_WIDTH_DEF = 32;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 32;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_MODE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLY_VALUE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_VALUE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFLECT_IN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFLECT_OUT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_XOR_OUT     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWAP_OUT    = 3'd6;

   // Width selector codes.
   localparam logic [1:0] WMODE_8  = 2'd0;
   localparam logic [1:0] WMODE_16 = 2'd1;
   localparam logic [1:0] WMODE_32 = 2'd2;

   // Input and result kinds.
   localparam logic KIND_MESSAGE = 1'b0;
   localparam logic KIND_CHECK   = 1'b1;
   localparam logic RES_APPEND   = 1'b0;
   localparam logic RES_VERDICT  = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [1:0]  WIDTH_MODE_RST  = WMODE_32;
   localparam logic [31:0] POLY_RST        = 32'h04C1_1DB7;
   localparam logic [31:0] INIT_RST        = 32'hFFFF_FFFF;
   localparam logic        REFLECT_IN_RST  = 1'b1;
   localparam logic        REFLECT_OUT_RST = 1'b1;
   localparam logic [31:0] XOR_OUT_RST     = 32'hFFFF_FFFF;
   localparam logic        SWAP_OUT_RST    = 1'b0;

   typedef struct packed {
      logic [1:0]  width_mode;
      logic [31:0] poly_value;
      logic [31:0] init_value;
      logic        reflect_in;
      logic        reflect_out;
      logic [31:0] xor_out;
      logic        swap_out;
   } cfg_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  code_byte;
      logic [31:0] crc_value;
      logic        check_ok;
      logic        last_of_run;
   } rsp_type;

   // One finished run handed from the datapath to the result stage.
   typedef struct packed {
      logic        result_kind;
      logic [31:0] crc_value;
      logic [2:0]  num_bytes;
      logic        check_ok;
   } job_type;

   // Byte idx of a code that is nb bytes long, most significant byte first.
   function automatic logic [7:0] code_byte_at(input logic [31:0] code,
                                               input logic [2:0]  idx,
                                               input logic [2:0]  nb);
      logic [1:0] pos;
      pos = 2'(nb - 3'd1 - idx);
      return code[{pos, 3'b000} +: 8];
   endfunction

endpackage

[sv/configurable_crc_append_check.sv]
// A transaction is registered in the input register and processed there; its results are
// registered in the result register. One byte per cycle unless req_stall; a message end
// issues one code byte per cycle (1, 2 or 4) unless rsp_stall, a frame end one verdict.
// The result register holds one run, so a transaction that ends a run waits while the
// previous run's results drain; others wait only behind such a one. Synchronous active-high
// reset restores the default CRC-32 settings and clears all message state; no clearing pass.
`timescale 1ns / 1ps

module configurable_crc_append_check #(
   parameter int MAX_CRC_WIDTH = ccrc_pkg::MAX_CRC_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ccrc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ccrc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ccrc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ccrc_pkg::rsp_type                   rsp_data
);
   import ccrc_pkg::*;

   cfg_type cfg;
   job_type job;
   logic    job_valid;
   logic    out_free;

   ccrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ccrc_core #(
      .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .job_valid (job_valid),
      .job       (job)
   );

   ccrc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/ccrc_csr.sv]
// Configuration registers of the CRC block, written through a plain write port.
// Depends on ccrc_pkg.
`timescale 1ns / 1ps

module ccrc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ccrc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ccrc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ccrc_pkg::cfg_type                   cfg
);
   import ccrc_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_mode  <= WIDTH_MODE_RST;
         cfg_ff.poly_value  <= POLY_RST;
         cfg_ff.init_value  <= INIT_RST;
         cfg_ff.reflect_in  <= REFLECT_IN_RST;
         cfg_ff.reflect_out <= REFLECT_OUT_RST;
         cfg_ff.xor_out     <= XOR_OUT_RST;
         cfg_ff.swap_out    <= SWAP_OUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH_MODE:  cfg_ff.width_mode  <= csr_wdata[1:0];
            CSR_POLY_VALUE:  cfg_ff.poly_value  <= csr_wdata;
            CSR_INIT_VALUE:  cfg_ff.init_value  <= csr_wdata;
            CSR_REFLECT_IN:  cfg_ff.reflect_in  <= csr_wdata[0];
            CSR_REFLECT_OUT: cfg_ff.reflect_out <= csr_wdata[0];
            CSR_XOR_OUT:     cfg_ff.xor_out     <= csr_wdata;
            CSR_SWAP_OUT:    cfg_ff.swap_out    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/ccrc_core.sv]
// Input register, CRC state and the one-byte fold, finish and check datapath.
// Depends on ccrc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccrc_core #(
   parameter int MAX_CRC_WIDTH = ccrc_pkg::MAX_CRC_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ccrc_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  ccrc_pkg::req_type   req_data,
   input  logic                out_free,
   output logic                job_valid,
   output ccrc_pkg::job_type   job
);
   import ccrc_pkg::*;

   localparam logic [5:0] WIDTH_CAP = 6'(MAX_CRC_WIDTH);

   logic        in_valid_ff, in_valid_in;
   req_type     in_ff;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] finished_ff, finished_in;
   logic [2:0]  check_index_ff, check_index_in;
   logic        check_failed_ff, check_failed_in;
   logic        in_check_ff, in_check_in;
   logic        msg_active_ff, msg_active_in;

   logic        advance;
   logic        accept;
   logic [5:0]  wsel;
   logic [5:0]  w;
   logic [4:0]  top_idx;
   logic [2:0]  nb;
   logic [31:0] mask;
   logic [31:0] crc_start;
   logic [7:0]  byte_in;
   logic [31:0] folded;
   logic [31:0] fin_src;
   logic [31:0] fin_rev;
   logic [31:0] fin_xor;
   logic [31:0] fin_code;
   logic        fold_path;
   logic [31:0] chk_code;
   logic [2:0]  chk_idx;
   logic        chk_match;
   logic        chk_failed_nx;
   logic [2:0]  chk_idx_nx;

   // An item that ends a run needs the result stage; others never wait.
   assign advance   = in_valid_ff && (!in_ff.last || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign job_valid = advance && in_ff.last;

   always_comb begin
      case (cfg.width_mode)
         WMODE_8:  wsel = 6'd8;
         WMODE_16: wsel = 6'd16;
         default:  wsel = 6'd32;
      endcase
      w       = (wsel > WIDTH_CAP) ? WIDTH_CAP : wsel;
      top_idx = 5'(w - 6'd1);
      nb      = 3'(w >> 3);
      mask    = (w >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
   end

   assign crc_start = msg_active_ff ? crc_ff : (cfg.init_value & mask);
   assign fold_path = (in_ff.kind == KIND_MESSAGE) && !in_check_ff;

   // Fold one byte into the register, eight shift and XOR steps.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_in[i] = cfg.reflect_in ? in_ff.data_byte[7-i] : in_ff.data_byte[i];
      end
      folded = crc_start ^ (32'(byte_in) << (w - 6'd8));
      for (int i = 0; i < 8; i++) begin
         if (folded[top_idx]) begin
            folded = ((folded << 1) ^ cfg.poly_value) & mask;
         end else begin
            folded = (folded << 1) & mask;
         end
      end
   end

   // Finish: optional reflection over the width, XOR, optional byte swap.
   always_comb begin
      fin_src = (fold_path ? folded : crc_start) & mask;
      fin_rev = '0;
      for (int i = 0; i < 32; i++) begin
         if (6'(i) < w) begin
            fin_rev[i] = fin_src[5'(w - 6'(i) - 6'd1)];
         end
      end
      fin_xor  = ((cfg.reflect_out ? fin_rev : fin_src) ^ cfg.xor_out) & mask;
      fin_code = fin_xor;
      if (cfg.swap_out && nb > 3'd1) begin
         fin_code = '0;
         for (int j = 0; j < 4; j++) begin
            if (3'(j) < nb) begin
               fin_code[8*j +: 8] = fin_xor[{2'(nb - 3'd1 - 3'(j)), 3'b000} +: 8];
            end
         end
      end
   end

   // Check of one received byte against the finished code.
   always_comb begin
      chk_code      = in_check_ff ? finished_ff : fin_code;
      chk_idx       = in_check_ff ? check_index_ff : 3'd0;
      chk_match     = (in_ff.kind == KIND_CHECK) && (chk_idx < nb) &&
                      (in_ff.data_byte == code_byte_at(chk_code, chk_idx, nb));
      chk_failed_nx = (in_check_ff && check_failed_ff) || !chk_match;
      chk_idx_nx    = (chk_idx == 3'd7) ? chk_idx : chk_idx + 3'd1;
   end

   always_comb begin
      crc_in          = crc_ff;
      finished_in     = finished_ff;
      check_index_in  = check_index_ff;
      check_failed_in = check_failed_ff;
      in_check_in     = in_check_ff;
      msg_active_in   = msg_active_ff;
      job             = '0;
      job.num_bytes   = nb;
      if (fold_path) begin
         job.result_kind = RES_APPEND;
         job.crc_value   = fin_code;
         if (in_ff.last) begin
            finished_in   = fin_code;
            msg_active_in = 1'b0;
         end else begin
            crc_in        = folded;
            msg_active_in = 1'b1;
         end
      end else begin
         job.result_kind = RES_VERDICT;
         job.crc_value   = chk_code;
         job.check_ok    = !chk_failed_nx && (chk_idx_nx == nb);
         finished_in     = chk_code;
         crc_in          = crc_start;
         if (in_ff.last) begin
            msg_active_in   = 1'b0;
            in_check_in     = 1'b0;
            check_index_in  = 3'd0;
            check_failed_in = 1'b0;
         end else begin
            msg_active_in   = 1'b1;
            in_check_in     = 1'b1;
            check_index_in  = chk_idx_nx;
            check_failed_in = chk_failed_nx;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         crc_ff          <= INIT_RST;
         finished_ff     <= '0;
         check_index_ff  <= 3'd0;
         check_failed_ff <= 1'b0;
         in_check_ff     <= 1'b0;
         msg_active_ff   <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            crc_ff          <= crc_in;
            finished_ff     <= finished_in;
            check_index_ff  <= check_index_in;
            check_failed_ff <= check_failed_in;
            in_check_ff     <= in_check_in;
            msg_active_ff   <= msg_active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
   end

   // The check phase always lies inside an open message.
   `CCRC_ASSERT(a_check_in_msg, clock, reset, in_check_ff |-> msg_active_ff)
   // A transaction that ends a run leaves the engine idle.
   `CCRC_ASSERT(a_idle_after_run, clock, reset,
      (advance && in_ff.last) |=> (!in_check_ff && !msg_active_ff && check_index_ff == 3'd0))

endmodule

[sv/ccrc_out.sv]
// Result register: holds one finished run and issues its code bytes or verdict.
// Depends on ccrc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccrc_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  ccrc_pkg::job_type   job,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ccrc_pkg::rsp_type   rsp_data
);
   import ccrc_pkg::*;

   logic        out_valid_ff, out_valid_in;
   job_type     job_ff;
   logic [1:0]  idx_ff, idx_in;
   logic        is_last;
   logic        fire;

   assign is_last  = (job_ff.result_kind == RES_VERDICT) ||
                     ({1'b0, idx_ff} == job_ff.num_bytes - 3'd1);
   assign fire     = out_valid_ff && !rsp_stall;
   assign out_free = !out_valid_ff || (fire && is_last);

   always_comb begin
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (job_valid) begin
         out_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (fire) begin
         if (is_last) begin
            out_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid) begin
         job_ff <= job;
      end
   end

   always_comb begin
      rsp_data.result_kind = job_ff.result_kind;
      rsp_data.crc_value   = job_ff.crc_value;
      rsp_data.check_ok    = job_ff.check_ok;
      rsp_data.last_of_run = is_last;
      rsp_data.code_byte   = (job_ff.result_kind == RES_VERDICT) ? 8'd0 :
                             code_byte_at(job_ff.crc_value, {1'b0, idx_ff},
                                          job_ff.num_bytes);
   end

   assign rsp_valid = out_valid_ff;

   // A new run is only handed over when the held one is gone.
   `CCRC_ASSERT(a_load_when_free, clock, reset, job_valid |-> out_free)
   // The byte counter stays within the code length.
   `CCRC_ASSERT(a_idx_in_range, clock, reset,
      out_valid_ff |-> ({1'b0, idx_ff} < job_ff.num_bytes))

endmodule

[tb/sv/crc_frame_checker.sv]
// Checker for the configurable CRC block: follows the register writes and both
// transaction channels, predicts every result and compares it field by field.
// Depends on ccrc_pkg for the transaction and configuration types and the register codes.
`timescale 1ns / 1ps

module crc_frame_checker
   import ccrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   output int                     fail_count,
   output int                     results_due
);

   cfg_type     cfg;
   logic [31:0] crc_reg;
   logic [31:0] fin_code;
   logic [2:0]  chk_idx;
   logic        chk_fail;
   logic        in_chk;
   logic        msg_on;
   rsp_type     due_q[$];

   function automatic int crc_len(input cfg_type c);
      if (c.width_mode == WMODE_8) return 1;
      if (c.width_mode == WMODE_16) return 2;
      return 4;
   endfunction

   function automatic logic [31:0] crc_mask(input cfg_type c);
      case (crc_len(c))
         1:       return 32'h0000_00FF;
         2:       return 32'h0000_FFFF;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // One message byte folded into the register, most significant bit first.
   function automatic logic [31:0] crc_fold(input cfg_type c, input logic [31:0] r,
                                            input logic [7:0] b);
      int          w;
      logic [31:0] m;
      logic [31:0] t;
      logic [7:0]  d;
      w = 8 * crc_len(c);
      m = crc_mask(c);
      d = b;
      if (c.reflect_in) begin
         for (int i = 0; i < 8; i++) d[i] = b[7 - i];
      end
      t = (r & m) ^ (32'(d) << (w - 8));
      for (int i = 0; i < 8; i++) begin
         if (t[w - 1]) begin
            t = ((t << 1) ^ c.poly_value) & m;
         end else begin
            t = (t << 1) & m;
         end
      end
      return t;
   endfunction

   function automatic logic [31:0] crc_finish(input cfg_type c, input logic [31:0] r);
      int          w;
      int          nb;
      logic [31:0] m;
      logic [31:0] t;
      logic [31:0] s;
      nb = crc_len(c);
      w  = 8 * nb;
      m  = crc_mask(c);
      t  = r & m;
      if (c.reflect_out) begin
         s = '0;
         for (int i = 0; i < w; i++) s[w - 1 - i] = t[i];
         t = s;
      end
      t = (t ^ c.xor_out) & m;
      if (c.swap_out && nb > 1) begin
         s = '0;
         for (int i = 0; i < nb; i++) s[8 * (nb - 1 - i) +: 8] = t[8 * i +: 8];
         t = s;
      end
      return t;
   endfunction

   function automatic void close_frame();
      msg_on   = 1'b0;
      chk_idx  = '0;
      chk_fail = 1'b0;
      in_chk   = 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("checker: %s", what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      int      nb;
      if (reset) begin
         cfg      = '{WIDTH_MODE_RST, POLY_RST, INIT_RST, REFLECT_IN_RST,
                      REFLECT_OUT_RST, XOR_OUT_RST, SWAP_OUT_RST};
         crc_reg  = INIT_RST;
         fin_code = '0;
         close_frame();
         due_q.delete();
      end else begin
         // Results are checked before the request of the same edge is predicted,
         // since no request can cause a result at the edge that accepts it.
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               report_mismatch($sformatf("result with no expectation waiting: %0h",
                                         rsp_data));
            end else begin
               want = due_q.pop_front();
               compare_field("result_kind", 32'(rsp_data.result_kind),
                             32'(want.result_kind));
               compare_field("code_byte", 32'(rsp_data.code_byte), 32'(want.code_byte));
               compare_field("crc_value", rsp_data.crc_value, want.crc_value);
               compare_field("check_ok", 32'(rsp_data.check_ok), 32'(want.check_ok));
               compare_field("last_of_run", 32'(rsp_data.last_of_run),
                             32'(want.last_of_run));
            end
         end

         if (csr_we) begin
            case (csr_index)
               CSR_WIDTH_MODE:  cfg.width_mode  = csr_wdata[1:0];
               CSR_POLY_VALUE:  cfg.poly_value  = csr_wdata;
               CSR_INIT_VALUE:  cfg.init_value  = csr_wdata;
               CSR_REFLECT_IN:  cfg.reflect_in  = csr_wdata[0];
               CSR_REFLECT_OUT: cfg.reflect_out = csr_wdata[0];
               CSR_XOR_OUT:     cfg.xor_out     = csr_wdata;
               CSR_SWAP_OUT:    cfg.swap_out    = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            nb = crc_len(cfg);
            if (req_data.kind == KIND_MESSAGE && !in_chk) begin
               if (!msg_on) begin
                  crc_reg = cfg.init_value & crc_mask(cfg);
                  msg_on  = 1'b1;
               end
               crc_reg = crc_fold(cfg, crc_reg, req_data.data_byte);
               if (req_data.last) begin
                  fin_code = crc_finish(cfg, crc_reg);
                  for (int k = 0; k < nb; k++) begin
                     want.result_kind = RES_APPEND;
                     want.code_byte   = 8'(fin_code >> (8 * (nb - 1 - k)));
                     want.crc_value   = fin_code;
                     want.check_ok    = 1'b0;
                     want.last_of_run = (k == nb - 1);
                     due_q.push_back(want);
                  end
                  close_frame();
               end
            end else begin
               // The first byte of the check phase fixes the code to compare with.
               if (!in_chk) begin
                  if (!msg_on) begin
                     crc_reg = cfg.init_value & crc_mask(cfg);
                     msg_on  = 1'b1;
                  end
                  fin_code = crc_finish(cfg, crc_reg);
                  in_chk   = 1'b1;
                  chk_idx  = '0;
                  chk_fail = 1'b0;
               end
               if (req_data.kind == KIND_CHECK && chk_idx < nb) begin
                  if (req_data.data_byte != 8'(fin_code >> (8 * (nb - 1 - int'(chk_idx)))))
                     chk_fail = 1'b1;
               end else begin
                  chk_fail = 1'b1;
               end
               if (chk_idx < 3'd7) chk_idx++;
               if (req_data.last) begin
                  want.result_kind = RES_VERDICT;
                  want.code_byte   = '0;
                  want.crc_value   = fin_code;
                  want.check_ok    = !chk_fail && (chk_idx == nb);
                  want.last_of_run = 1'b1;
                  due_q.push_back(want);
                  close_frame();
               end
            end
         end
      end
      results_due = due_q.size();
   end

endmodule

[tb/sv/tb_configurable_crc_append_check.sv]
// Top of the CRC block's testbench: clock, reset, register writes and frame stimulus.
// Depends on ccrc_pkg, the block itself and crc_frame_checker, which predicts the
// results and returns the failure count used for the verdict here.
`timescale 1ns / 1ps

module tb_configurable_crc_append_check;
   import ccrc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam logic [1:0]  WMODE_UNUSED = 2'd3;

   typedef logic [7:0] byte_list_type[$];

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;

   int          fail_count;
   int          results_due;
   int          items_sent    = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int unsigned cycle_count   = 0;
   cfg_type     cur_cfg;

   configurable_crc_append_check i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   crc_frame_checker i_chk (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall   <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return POLY_RST;
         3:       return 32'h0000_1021;
         4:       return 32'h0000_8005;
         5:       return 32'h0000_0031;
         6:       return 32'h0000_0007;
         default: return $urandom();
      endcase
   endfunction

   // Writes every register on consecutive edges; unused upper bits carry noise.
   task automatic load_config(input cfg_type c);
      for (int i = int'(CSR_WIDTH_MODE); i <= int'(CSR_SWAP_OUT); i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[CSR_INDEX_W-1:0];
         case (i[CSR_INDEX_W-1:0])
            CSR_WIDTH_MODE:  csr_wdata <= ($urandom() & 32'hFFFF_FFFC) | 32'(c.width_mode);
            CSR_POLY_VALUE:  csr_wdata <= c.poly_value;
            CSR_INIT_VALUE:  csr_wdata <= c.init_value;
            CSR_REFLECT_IN:  csr_wdata <= ($urandom() & 32'hFFFF_FFFE) | 32'(c.reflect_in);
            CSR_REFLECT_OUT: csr_wdata <= ($urandom() & 32'hFFFF_FFFE) | 32'(c.reflect_out);
            CSR_XOR_OUT:     csr_wdata <= c.xor_out;
            CSR_SWAP_OUT:    csr_wdata <= ($urandom() & 32'hFFFF_FFFE) | 32'(c.swap_out);
            default:         csr_wdata <= '0;
         endcase
         @(posedge clock);
      end
      csr_we  <= 1'b0;
      cur_cfg = c;
   endtask

   task automatic send_item(input logic kind, input logic [7:0] data, input logic last);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind, data, last};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Sends a message to be appended to, or a message followed by its check bytes.
   // A check frame may run short or long, carry one flipped bit, or have a stray
   // message byte slipped in before check byte stray_at (at the end, it closes
   // the frame).
   task automatic send_frame(input byte_list_type msg, input logic as_check,
                             input int chk_len, input int flip_at, input int stray_at);
      int          nb;
      logic [31:0] acc;
      logic [31:0] code;
      logic [7:0]  b;
      nb  = i_chk.crc_len(cur_cfg);
      acc = cur_cfg.init_value & i_chk.crc_mask(cur_cfg);
      foreach (msg[i]) begin
         acc = i_chk.crc_fold(cur_cfg, acc, msg[i]);
         send_item(KIND_MESSAGE, msg[i], !as_check && (i == msg.size() - 1));
      end
      if (as_check) begin
         code = i_chk.crc_finish(cur_cfg, acc);
         for (int i = 0; i < chk_len; i++) begin
            if (i == stray_at) send_item(KIND_MESSAGE, 8'($urandom()), 1'b0);
            b = (i < nb) ? 8'(code >> (8 * (nb - 1 - i))) : 8'($urandom());
            if (i == flip_at) b ^= 8'(1 << $urandom_range(0, 7));
            send_item(KIND_CHECK, b, (i == chk_len - 1) && (stray_at != chk_len));
         end
         if (stray_at == chk_len) send_item(KIND_MESSAGE, 8'($urandom()), 1'b1);
      end
   endtask

   // Mostly well-formed frames with random content, the rest deliberately broken.
   task automatic random_frame();
      byte_list_type msg;
      int            nb;
      int            shape;
      int            chk_len;
      int            flip_at;
      int            stray_at;
      nb       = i_chk.crc_len(cur_cfg);
      shape    = $urandom_range(0, 99);
      chk_len  = nb;
      flip_at  = -1;
      stray_at = -1;
      repeat (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8))
         msg.push_back(8'($urandom()));
      if (shape < 40) begin
         if (msg.size() == 0) msg.push_back(8'($urandom()));
         send_frame(msg, 1'b0, 0, -1, -1);
      end else begin
         if (shape >= 96) stray_at = $urandom_range(1, nb);
         else if (shape >= 90) chk_len = $urandom_range(nb + 1, 9);
         else if (shape >= 84) chk_len = $urandom_range(1, nb);
         else if (shape >= 74) flip_at = $urandom_range(0, nb - 1);
         send_frame(msg, 1'b1, chk_len, flip_at, stray_at);
      end
   endtask

   // Waits until every predicted result has arrived, then lets the pipeline settle,
   // as a message byte without an end still travels through it unseen.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      cfg_type       c;
      byte_list_type msg;
      int            target;
      cur_cfg = '{WIDTH_MODE_RST, POLY_RST, INIT_RST, REFLECT_IN_RST,
                  REFLECT_OUT_RST, XOR_OUT_RST, SWAP_OUT_RST};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: appends, a check of the empty message, a short check.
      msg = '{8'h00};
      send_frame(msg, 1'b0, 0, -1, -1);
      msg = '{8'hFF, 8'hA5};
      send_frame(msg, 1'b0, 0, -1, -1);
      msg = {};
      send_frame(msg, 1'b1, 4, -1, -1);
      msg = '{8'h31};
      send_frame(msg, 1'b1, 3, -1, -1);
      drain();

      // Eight bits: a good check, one extra check byte, a stray message byte at the end.
      load_config('{WMODE_8, 32'h0000_0007, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b1});
      msg = '{8'h55};
      send_frame(msg, 1'b1, 1, -1, -1);
      msg = '{8'h12};
      send_frame(msg, 1'b1, 2, -1, -1);
      msg = {};
      send_frame(msg, 1'b1, 1, -1, 1);
      drain();

      load_config('{WMODE_16, 32'h0000_1021, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b1});
      msg = '{8'h80};
      send_frame(msg, 1'b0, 0, -1, -1);
      msg = '{8'h7F};
      send_frame(msg, 1'b1, 2, 0, -1);
      drain();

      // The unused width selector behaves as thirty-two bits.
      load_config('{WMODE_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1,
                    32'hFFFF_FFFF, 1'b1});
      msg = '{8'h01};
      send_frame(msg, 1'b0, 0, -1, -1);
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 58; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 58; end
            default: begin send_idle_pct = 8;  stall_pct = 8;  end
         endcase
         c.width_mode  = 2'($urandom_range(0, 3));
         c.poly_value  = pick_word();
         c.init_value  = pick_word();
         c.reflect_in  = 1'($urandom_range(0, 1));
         c.reflect_out = 1'($urandom_range(0, 1));
         c.xor_out     = pick_word();
         c.swap_out    = 1'($urandom_range(0, 1));
         load_config(c);
         target = items_sent + 25;
         while (items_sent < target) random_frame();
         drain();
      end

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
